FILE: rtl/video_ram_port_auto_increment_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the video RAM port
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef VIDEO_RAM_PORT_AUTO_INCREMENT_CORE_DEFINES_SVH
`define VIDEO_RAM_PORT_AUTO_INCREMENT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VRPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vrpa: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define VRPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vrpa: next-cycle check failed");

`endif

FILE: rtl/vrpa_pkg.sv
// ----------------------------------------------------------------------------
// vrpa_pkg
// Constants, command codes and the command type shared by the video RAM
// port front end, command queue and execution unit.
// ----------------------------------------------------------------------------
package vrpa_pkg;

	localparam int ADDR_BITS = 16;
	localparam int MEM_WORDS = 1 << ADDR_BITS;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] BAD_WORD = 16'hF0F0;

	// Port register offsets
	localparam logic [3:0] OFF_POINTER = 4'h0;
	localparam logic [3:0] OFF_DATA    = 4'h2;
	localparam logic [3:0] OFF_STRIDE  = 4'h4;
	localparam logic [2:0] RD_POINTER  = 3'h0;
	localparam logic [2:0] RD_DATA     = 3'h2;
	localparam logic [2:0] RD_STRIDE   = 3'h4;

	// Command codes
	localparam logic [2:0] OP_NOP        = 3'd0;
	localparam logic [2:0] OP_SET_PTR    = 3'd1;
	localparam logic [2:0] OP_STORE      = 3'd2;
	localparam logic [2:0] OP_SET_STRIDE = 3'd3;
	localparam logic [2:0] OP_RD_BUF     = 3'd4;
	localparam logic [2:0] OP_RD_STRIDE  = 3'd5;
	localparam logic [2:0] OP_RD_BAD     = 3'd6;

	typedef struct packed {
		logic [2:0]  op;
		logic        hi_byte;
		logic [15:0] data;
	} cmd_t;

endpackage

FILE: rtl/vrpa_if.sv
// ----------------------------------------------------------------------------
// vrpa_req_if / vrpa_rsp_if
// Valid/ready channels for bus requests into the port and results out of it.
// ----------------------------------------------------------------------------
interface vrpa_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [3:0]  reg_offset;
	logic        byte_access;
	logic [15:0] write_data;

	modport source (output valid, output action, output reg_offset,
		output byte_access, output write_data, input ready);
	modport sink (input valid, input action, input reg_offset,
		input byte_access, input write_data, output ready);
endinterface

interface vrpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        invalid_access;

	modport source (output valid, output read_data, output invalid_access, input ready);
	modport sink (input valid, input read_data, input invalid_access, output ready);
endinterface

FILE: rtl/vrpa_front.sv
// ----------------------------------------------------------------------------
// vrpa_front
// Accepts bus requests and classifies each into a port command, held in a
// single register stage ahead of the command queue.
// ----------------------------------------------------------------------------
module vrpa_front (
	input  logic          clk,
	input  logic          arst_n,
	vrpa_req_if.sink      req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output vrpa_pkg::cmd_t cmd
);

	logic           valid_s1;
	vrpa_pkg::cmd_t cmd_s1;
	vrpa_pkg::cmd_t decoded;

	always_comb begin
		decoded.hi_byte = req.byte_access;
		decoded.op      = vrpa_pkg::OP_NOP;
		// A byte write stores its byte in both halves of the word.
		decoded.data    = req.byte_access ? {req.write_data[7:0], req.write_data[7:0]}
			: req.write_data;
		if (req.action) begin
			// Odd offsets never match, so odd byte writes fall out as no-ops.
			unique case (req.reg_offset)
				vrpa_pkg::OFF_POINTER: decoded.op = vrpa_pkg::OP_SET_PTR;
				vrpa_pkg::OFF_DATA:    decoded.op = vrpa_pkg::OP_STORE;
				vrpa_pkg::OFF_STRIDE:  decoded.op = vrpa_pkg::OP_SET_STRIDE;
				default:               decoded.op = vrpa_pkg::OP_NOP;
			endcase
		end else begin
			// Reads decode only the low three offset bits.
			unique case (req.reg_offset[2:0])
				vrpa_pkg::RD_POINTER: decoded.op = vrpa_pkg::OP_RD_BUF;
				vrpa_pkg::RD_DATA:    decoded.op = vrpa_pkg::OP_RD_BUF;
				vrpa_pkg::RD_STRIDE:  decoded.op = vrpa_pkg::OP_RD_STRIDE;
				default:              decoded.op = vrpa_pkg::OP_RD_BAD;
			endcase
		end
	end

	assign req.ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1 <= decoded;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

FILE: rtl/vrpa_queue.sv
// ----------------------------------------------------------------------------
// vrpa_queue
// Short command queue that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
module vrpa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vrpa_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output vrpa_pkg::cmd_t out_cmd
);

	localparam int PTR_BITS = $clog2(vrpa_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(vrpa_pkg::QUEUE_DEPTH + 1);

	vrpa_pkg::cmd_t        entry_q [vrpa_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = count_q != CNT_BITS'(vrpa_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(vrpa_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(vrpa_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

FILE: rtl/vrpa_back.sv
// ----------------------------------------------------------------------------
// vrpa_back
// Execution unit: holds the pointer, stride and read buffer, owns the video
// memory, carries out one command at a time and registers its result.
// ----------------------------------------------------------------------------
`include "video_ram_port_auto_increment_core_defines.svh"

module vrpa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  vrpa_pkg::cmd_t cmd,
	vrpa_rsp_if.source     rsp
);

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [15:0] mem [vrpa_pkg::MEM_WORDS];
	logic [15:0] mem_rdata_q;

	logic [1:0]  state_q;
	logic [15:0] pointer_q;
	logic [15:0] stride_q;
	logic [15:0] buffer_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_inv_q;

	logic        cmd_pop;
	logic        mem_we;
	logic [15:0] word;
	logic [15:0] result;

	assign cmd_ready = (state_q == ST_RUN) && (!out_valid_q || rsp.ready);
	assign cmd_pop   = cmd_valid && cmd_ready;
	assign mem_we    = cmd_pop && (cmd.op == vrpa_pkg::OP_STORE);

	always_comb begin
		unique case (cmd.op)
			vrpa_pkg::OP_RD_BUF:    word = buffer_q;
			vrpa_pkg::OP_RD_STRIDE: word = stride_q;
			vrpa_pkg::OP_RD_BAD:    word = vrpa_pkg::BAD_WORD;
			default:                word = '0;
		endcase
		result = cmd.hi_byte ? {8'h00, word[15:8]} : word;
	end

	// The read in the fill state sees a store made in the cycle before.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pointer_q[vrpa_pkg::ADDR_BITS-1:0]] <= cmd.data;
		end
		if (state_q == ST_FILL) begin
			mem_rdata_q <= mem[pointer_q[vrpa_pkg::ADDR_BITS-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			pointer_q   <= '0;
			stride_q    <= '0;
			buffer_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							vrpa_pkg::OP_SET_PTR: begin
								pointer_q <= cmd.data;
								state_q   <= ST_FILL;
							end
							vrpa_pkg::OP_STORE: begin
								// Bit 15 stays put; the low fifteen bits wrap.
								pointer_q <= {pointer_q[15], pointer_q[14:0] + stride_q[14:0]};
								state_q   <= ST_FILL;
							end
							vrpa_pkg::OP_SET_STRIDE: begin
								stride_q <= {cmd.data[14], cmd.data[14:0]};
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: state_q <= ST_LOAD;
				ST_LOAD: begin
					buffer_q <= mem_rdata_q;
					state_q  <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase

			if (cmd_pop) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_data_q <= result;
			out_inv_q  <= cmd.op == vrpa_pkg::OP_RD_BAD;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_data      = out_data_q;
	assign rsp.invalid_access = out_inv_q;

	`VRPA_ASSERT_NEXT(a_ptr_fills, clk, arst_n,
		cmd_pop && (cmd.op == vrpa_pkg::OP_SET_PTR || cmd.op == vrpa_pkg::OP_STORE),
		state_q == ST_FILL)
	`VRPA_ASSERT_NEXT(a_fill_loads, clk, arst_n, state_q == ST_FILL, state_q == ST_LOAD)
	`VRPA_ASSERT_NEXT(a_stride_sign, clk, arst_n,
		cmd_pop && cmd.op == vrpa_pkg::OP_SET_STRIDE, stride_q[15] == stride_q[14])
	`VRPA_ASSERT_SAME(a_write_zero, clk, arst_n,
		cmd_pop && (cmd.op == vrpa_pkg::OP_NOP || cmd.op == vrpa_pkg::OP_STORE),
		result == 16'h0000)

endmodule

FILE: rtl/video_ram_port_auto_increment_core.sv
// ----------------------------------------------------------------------------
// video_ram_port_auto_increment_core
// Indirect video memory port with pointer auto-increment, seen by a CPU.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one bus request (action, reg_offset, byte_access, write_data);
//   rsp returns exactly one result per request, in order (read_data,
//   invalid_access). Writes return zero.
//   A request passes a decode register and a two-entry command queue before
//   the execution unit, which registers its result.
//   Reads, stride writes and ignored writes complete as the execution unit
//   takes them. A pointer write or a data write updates the pointer, then
//   steps through the fill and load states for the registered read of the
//   video memory that refills the read buffer, taking no command meanwhile.
//   Sustained rate is one request per cycle for the former if rsp is ready.
//   Reset clears the pointer, stride and read buffer and empties the queue;
//   video memory contents are undefined until written.
//   When rsp is stalled the result is held, further requests fill the decode
//   register and the queue, and req.ready then falls.
// ----------------------------------------------------------------------------
module video_ram_port_auto_increment_core (
	input  logic       clk,
	input  logic       arst_n,
	vrpa_req_if.sink   req,
	vrpa_rsp_if.source rsp
);

	logic           front_valid;
	logic           front_ready;
	vrpa_pkg::cmd_t front_cmd;
	logic           back_valid;
	logic           back_ready;
	vrpa_pkg::cmd_t back_cmd;

	vrpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	vrpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_cmd   (back_cmd)
	);

	vrpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.rsp       (rsp)
	);

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the auto-increment video RAM port. Bus requests are driven on the
// request channel with random gaps, and every result on the response channel
// is compared with a shadow model of pointer, stride, read buffer and video
// memory that is updated as each request is accepted.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int IDLE_PERCENT   = 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int HOLD_CYCLES    = 200;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
	localparam logic ACC_WORD  = 1'b0;
	localparam logic ACC_BYTE  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [3:0]  reg_offset;
		logic        byte_access;
		logic [15:0] write_data;
	} bus_request_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        invalid_access;
	} bus_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vrpa_req_if req_bus ();
	vrpa_rsp_if rsp_bus ();

	video_ram_port_auto_increment_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Shadow state of the port
	logic [15:0] shadow_pointer = '0;
	logic [15:0] shadow_stride  = '0;
	logic [15:0] shadow_buffer  = '0;
	bit          buffer_known   = 1'b1;
	logic [15:0] shadow_vram [int];

	bus_result_t pending_results [$];

	bit no_idle = 1'b0;
	int hold_request = 0;
	int rsp_hold_left = 0;

	int requests_sent = 0;
	int reads_sent = 0;
	int writes_sent = 0;
	int results_checked = 0;
	int mismatch_count = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void refill_buffer();
		int idx;
		idx = int'(shadow_pointer) & (vrpa_pkg::MEM_WORDS - 1);
		if (shadow_vram.exists(idx)) begin
			shadow_buffer = shadow_vram[idx];
			buffer_known = 1'b1;
		end else begin
			shadow_buffer = '0;
			buffer_known = 1'b0;
		end
	endfunction

	function automatic bus_result_t predict_access(input bus_request_t r);
		bus_result_t res;
		logic [15:0] word;
		logic [15:0] wdata;
		res.read_data = '0;
		res.invalid_access = 1'b0;
		if (r.action == ACT_WRITE) begin
			if (r.byte_access == ACC_WORD || !r.reg_offset[0]) begin
				wdata = (r.byte_access == ACC_BYTE) ? {2{r.write_data[7:0]}} : r.write_data;
				case (r.reg_offset)
					vrpa_pkg::OFF_POINTER: begin
						shadow_pointer = wdata;
						refill_buffer();
					end
					vrpa_pkg::OFF_DATA: begin
						shadow_vram[int'(shadow_pointer) & (vrpa_pkg::MEM_WORDS - 1)] = wdata;
						// Bit 15 survives the advance; the low fifteen bits wrap.
						shadow_pointer = {shadow_pointer[15],
							shadow_pointer[14:0] + shadow_stride[14:0]};
						refill_buffer();
					end
					vrpa_pkg::OFF_STRIDE: shadow_stride = {wdata[14], wdata[14:0]};
					default: ;
				endcase
			end
		end else if (r.byte_access == ACC_BYTE && r.reg_offset[0]) begin
			res.read_data = {8'h00, vrpa_pkg::BAD_WORD[15:8]};
			res.invalid_access = 1'b1;
		end else begin
			case (r.reg_offset[2:0])
				vrpa_pkg::RD_POINTER, vrpa_pkg::RD_DATA: word = shadow_buffer;
				vrpa_pkg::RD_STRIDE: word = shadow_stride;
				default: begin
					word = vrpa_pkg::BAD_WORD;
					res.invalid_access = 1'b1;
				end
			endcase
			res.read_data = (r.byte_access == ACC_BYTE) ? {8'h00, word[15:8]} : word;
		end
		return res;
	endfunction

	// Drives one request from a falling edge and returns at the falling edge after
	// it has been accepted, leaving valid high for a request that follows at once.
	task automatic issue_request(input logic act, input logic [3:0] off, input logic byt,
			input logic [15:0] wdata);
		bus_request_t r;
		r.action = act;
		r.reg_offset = off;
		r.byte_access = byt;
		r.write_data = wdata;
		// The buffer may hold a word never written; such a read is steered to the stride.
		if (r.action == ACT_READ && !(r.byte_access == ACC_BYTE && r.reg_offset[0]) &&
				(r.reg_offset[2:0] == vrpa_pkg::RD_POINTER ||
				r.reg_offset[2:0] == vrpa_pkg::RD_DATA) &&
				!buffer_known)
			r.reg_offset = {r.reg_offset[3], vrpa_pkg::RD_STRIDE};
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.action <= r.action;
		req_bus.reg_offset <= r.reg_offset;
		req_bus.byte_access <= r.byte_access;
		req_bus.write_data <= r.write_data;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		pending_results.push_back(predict_access(r));
		requests_sent++;
		if (r.action == ACT_READ)
			reads_sent++;
		else
			writes_sent++;
		@(negedge clk);
	endtask

	// Response side: random stalls, a quiet stretch, and a long hold-off on request.
	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				rsp_hold_left = hold_request;
				hold_request = 0;
			end
			if (rsp_hold_left > 0) begin
				rsp_hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (no_idle) begin
				rsp_bus.ready <= 1'b1;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin : result_check
		bus_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: read_data %h invalid_access %b",
					rsp_bus.read_data, rsp_bus.invalid_access);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_bus.read_data !== want.read_data) begin
					$error("read_data: expected %h, actual %h", want.read_data,
						rsp_bus.read_data);
					mismatch_count++;
				end
				if (rsp_bus.invalid_access !== want.invalid_access) begin
					$error("invalid_access: expected %b, actual %b", want.invalid_access,
						rsp_bus.invalid_access);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic test_reset_state();
		issue_request(ACT_READ, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h0000);
		issue_request(ACT_READ, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'hFFFF);
		issue_request(ACT_READ, vrpa_pkg::OFF_DATA, ACC_BYTE, 16'h0000);
	endtask

	task automatic test_stride_register();
		// Bit 14 of the written value is copied into bit 15.
		issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'h4001);
		issue_request(ACT_READ, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'h0000);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'h8002);
		issue_request(ACT_READ, 4'hC, ACC_WORD, 16'h0000);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_BYTE, 16'hA55A);
		issue_request(ACT_READ, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'h0000);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'hFFFF);
		issue_request(ACT_READ, vrpa_pkg::OFF_STRIDE, ACC_BYTE, 16'h0000);
	endtask

	task automatic test_pointer_and_data();
		issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'h0001);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_DATA, ACC_WORD, 16'h1234);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_DATA, ACC_WORD, 16'hABCD);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_DATA, ACC_BYTE, 16'hFF3C);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h0000);
		issue_request(ACT_READ, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h0000);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h0001);
		issue_request(ACT_READ, 4'hA, ACC_BYTE, 16'h0000);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h0002);
		issue_request(ACT_READ, 4'h8, ACC_WORD, 16'h0000);
	endtask

	task automatic test_ignored_and_unmapped();
		issue_request(ACT_WRITE, 4'h3, ACC_BYTE, 16'hFFFF);
		issue_request(ACT_WRITE, 4'h6, ACC_WORD, 16'hFFFF);
		issue_request(ACT_WRITE, 4'h8, ACC_WORD, 16'h0000);
		issue_request(ACT_READ, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h0000);
		issue_request(ACT_READ, 4'h1, ACC_WORD, 16'h0000);
		issue_request(ACT_READ, 4'h6, ACC_WORD, 16'h0000);
		issue_request(ACT_READ, 4'hE, ACC_WORD, 16'h0000);
		issue_request(ACT_READ, 4'h5, ACC_BYTE, 16'h0000);
		issue_request(ACT_READ, 4'h6, ACC_BYTE, 16'h0000);
	endtask

	task automatic test_pointer_wrap();
		// With the top bit set the advance stays in the upper half.
		issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'h3FFF);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h8000);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_DATA, ACC_WORD, 16'hFFFF);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_DATA, ACC_WORD, 16'h0000);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h8000);
		issue_request(ACT_READ, vrpa_pkg::OFF_DATA, ACC_WORD, 16'h0000);
		// From the top of the lower half the pointer wraps to word zero.
		issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD, 16'h0001);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, 16'h7FFF);
		issue_request(ACT_WRITE, vrpa_pkg::OFF_DATA, ACC_WORD, 16'h5555);
		issue_request(ACT_READ, vrpa_pkg::OFF_DATA, ACC_WORD, 16'h0000);
	endtask

	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		repeat (40) begin
			if ($urandom_range(3) == 0)
				issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD,
					16'($urandom_range(16'hFFFF)));
			else
				issue_request(ACT_READ, 4'($urandom_range(15)), 1'($urandom_range(1)),
					16'h0000);
		end
	endtask

	task automatic test_random_bursts(input int target);
		logic [15:0] visited [$];
		logic [15:0] region_base;
		logic [15:0] base;
		logic [15:0] stride_value;
		int first_request;
		int done;
		region_base = 16'($urandom_range(16'hFFFF));
		first_request = requests_sent;
		done = 0;
		while (done < target) begin
			no_idle = (done >= target / 3) && (done < target / 2);
			if ($urandom_range(99) < 25) begin
				repeat ($urandom_range(1, 6))
					issue_request(1'($urandom_range(1)), 4'($urandom_range(15)),
						1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
			end else begin
				case ($urandom_range(3))
					0: stride_value = 16'($urandom_range(1, 4));
					1: stride_value = 16'($urandom_range(16'hFFFF));
					2: begin
						case ($urandom_range(3))
							0: stride_value = 16'h0000;
							1: stride_value = 16'h7FFF;
							2: stride_value = 16'hFFFF;
							default: stride_value = 16'h4000;
						endcase
					end
					default: stride_value = 16'($urandom_range(40));
				endcase
				issue_request(ACT_WRITE, vrpa_pkg::OFF_STRIDE, ACC_WORD, stride_value);
				if ($urandom_range(1))
					base = region_base + 16'($urandom_range(31));
				else
					base = 16'($urandom_range(16'hFFFF));
				if ($urandom_range(9) == 0)
					issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_BYTE, base);
				else
					issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, base);
				visited.delete();
				repeat ($urandom_range(1, 8)) begin
					visited.push_back(shadow_pointer);
					issue_request(ACT_WRITE, vrpa_pkg::OFF_DATA, 1'($urandom_range(4) == 0),
						16'($urandom_range(16'hFFFF)));
					if ($urandom_range(2) == 0)
						issue_request(ACT_READ, 4'($urandom_range(1) * 2),
							1'($urandom_range(1)), 16'h0000);
				end
				visited.shuffle();
				foreach (visited[i]) begin
					issue_request(ACT_WRITE, vrpa_pkg::OFF_POINTER, ACC_WORD, visited[i]);
					issue_request(ACT_READ, 4'($urandom_range(1) * 8 + $urandom_range(1) * 2),
						1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
				end
			end
			done = requests_sent - first_request;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		req_bus.valid = 1'b0;
		req_bus.action = ACT_READ;
		req_bus.reg_offset = vrpa_pkg::OFF_POINTER;
		req_bus.byte_access = ACC_WORD;
		req_bus.write_data = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_stride_register();
		test_pointer_and_data();
		test_ignored_and_unmapped();
		test_pointer_wrap();
		test_backpressure();
		test_random_bursts(1570);

		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d reads, %0d writes) through pointer, data, stride,",
			requests_sent, reads_sent, writes_sent);
		$display("alias and unmapped offsets; %0d results checked, %0d mismatches.",
			results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/vrpa_pkg.sv
rtl/vrpa_if.sv
rtl/vrpa_front.sv
rtl/vrpa_queue.sv
rtl/vrpa_back.sv
rtl/video_ram_port_auto_increment_core.sv
bench/tb_top.sv
